/* hdl/framed_ascii_command_decoder_assert.svh */
// Assertion macros used by the SVA checker in hdl/facd_checker.sv.
`ifndef FRAMED_ASCII_COMMAND_DECODER_ASSERT_SVH
`define FRAMED_ASCII_COMMAND_DECODER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define FACD_ASSERT_IMP(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define FACD_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

/* hdl/facd_pkg.sv */
`default_nettype none

package facd_pkg;

  localparam logic [7:0] START_MARK = 8'h24;  // '$'
  localparam logic [7:0] END_MARK   = 8'h23;  // '#'
  localparam logic [7:0] ASCII_ZERO = 8'd48;
  localparam logic [7:0] SPACE_CHAR = 8'h20;
  localparam logic [7:0] CHAR_M     = 8'h4D;
  localparam logic [7:0] CHAR_C     = 8'h43;
  localparam logic [7:0] CHAR_I     = 8'h49;
  localparam logic [7:0] CHAR_T     = 8'h54;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_1     = 8'h31;
  localparam logic [7:0] CHAR_2     = 8'h32;
  localparam logic [7:0] CHAR_3     = 8'h33;

  localparam logic [15:0] RATE_RESET      = 16'd2500;
  localparam logic [31:0] RATE_TEXT_RESET = 32'h3235_3030;
  localparam logic [7:0]  CHAN_RESET      = 8'd2;
  localparam logic [7:0]  CHAN_CHAR_RESET = 8'h32;

  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_STOP  = 3'd1,
    CMD_START = 3'd2,
    CMD_RATE  = 3'd3,
    CMD_CHAN  = 3'd4,
    CMD_TEST1 = 3'd5,
    CMD_TEST2 = 3'd6,
    CMD_TEST3 = 3'd7
  } cmd_e;

endpackage

`default_nettype wire

/* hdl/framed_ascii_command_decoder.sv */
`default_nettype none

// Framed ASCII command decoder. Takes one received character per cycle on
// the input channel while in_ready_o is high, with no stall of its own. A frame
// opens with '$' and closes with '#'; bytes in between fill an internal
// frame store of FRAME_MAX bytes, and a frame that fills the store is
// dropped without a result. Each closing '#' yields exactly one result on
// the edge after it is accepted: new_command tells whether the frame
// matched a command, and the other fields show the command, rate, rate text
// and channel registers as they stand after the frame. Bytes outside a
// frame yield nothing. The frame store keeps bytes of earlier frames, and a
// short frame decodes them as they stand. The result sits in an output
// register; the input stays ready while that register is empty or being
// taken in the same cycle, so the rate is set only by the consumer.
module framed_ascii_command_decoder #(
  parameter int unsigned FRAME_MAX = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_ready_o,
  input  wire logic [7:0]  rx_byte_i,
  output      logic        out_valid_o,
  input  wire logic        out_ready_i,
  output      logic        new_command_o,
  output      logic [2:0]  command_code_o,
  output      logic [15:0] rate_value_o,
  output      logic [31:0] rate_text_o,
  output      logic [7:0]  channel_value_o,
  output      logic [7:0]  channel_char_o
);

  import facd_pkg::*;

  localparam int unsigned CntW = $clog2(FRAME_MAX + 1);
  localparam int unsigned IdxW = $clog2(FRAME_MAX);

  logic            receiving_q, receiving_d;
  logic [CntW-1:0] wr_idx_q, wr_idx_d;
  logic [7:0]      frame_q [FRAME_MAX];
  logic [2:0]      cmd_q, cmd_d;
  logic [15:0]     rate_q, rate_d;
  logic [31:0]     text_q, text_d;
  logic [7:0]      chan_q, chan_d;
  logic [7:0]      chch_q, chch_d;
  logic            out_valid_q, out_valid_d;
  logic            hit_q, hit_d;

  logic            accept;
  logic            store_en;
  logic            frame_end;
  logic            hit;
  logic [7:0]      f0, f1, f2, f3, f4, f5;
  logic [15:0]     d2, d3, d4, d5;

  assign accept    = in_valid_i && in_ready_o;
  assign frame_end = receiving_q && (rx_byte_i == END_MARK);
  assign store_en  = accept && receiving_q && (rx_byte_i != END_MARK)
                     && (wr_idx_q < CntW'(FRAME_MAX));

  assign f0 = frame_q[0];
  assign f1 = frame_q[1];
  assign f2 = frame_q[2];
  assign f3 = frame_q[3];
  assign f4 = frame_q[4];
  assign f5 = frame_q[5];

  // digit values wrap modulo 2^16, no check that bytes are digits
  assign d2 = {8'h00, f2} - {8'h00, ASCII_ZERO};
  assign d3 = {8'h00, f3} - {8'h00, ASCII_ZERO};
  assign d4 = {8'h00, f4} - {8'h00, ASCII_ZERO};
  assign d5 = {8'h00, f5} - {8'h00, ASCII_ZERO};

  // decode the stored frame into the next command registers
  always_comb begin
    hit    = 1'b0;
    cmd_d  = cmd_q;
    rate_d = rate_q;
    text_d = text_q;
    chan_d = chan_q;
    chch_d = chch_q;
    case (f0)
      CHAR_M: begin
        if (f1 == CHAR_0) begin
          hit   = 1'b1;
          cmd_d = CMD_STOP;
        end else if (f1 == CHAR_1) begin
          hit   = 1'b1;
          cmd_d = CMD_START;
        end
      end
      CHAR_C: begin
        if (f1 == CHAR_COMMA) begin
          hit   = 1'b1;
          cmd_d = CMD_RATE;
          if (f4 == CHAR_DOT) begin
            rate_d = 16'(d2 * 16'd10) + d3;
            text_d = {SPACE_CHAR, SPACE_CHAR, f2, f3};
          end else if (f5 == CHAR_DOT) begin
            rate_d = 16'(d2 * 16'd100) + 16'(d3 * 16'd10) + d4;
            text_d = {SPACE_CHAR, f2, f3, f4};
          end else begin
            rate_d = 16'(d2 * 16'd1000) + 16'(d3 * 16'd100)
                     + 16'(d4 * 16'd10) + d5;
            text_d = {f2, f3, f4, f5};
          end
        end
      end
      CHAR_I: begin
        if ((f1 == CHAR_COMMA) && (f3 == CHAR_DOT)) begin
          hit    = 1'b1;
          cmd_d  = CMD_CHAN;
          chan_d = f2 - ASCII_ZERO;
          chch_d = f2;
        end
      end
      CHAR_T: begin
        if (f1 == CHAR_1) begin
          hit   = 1'b1;
          cmd_d = CMD_TEST1;
        end else if (f1 == CHAR_2) begin
          hit   = 1'b1;
          cmd_d = CMD_TEST2;
        end else if (f1 == CHAR_3) begin
          hit   = 1'b1;
          cmd_d = CMD_TEST3;
        end
      end
      default: begin
        hit = 1'b0;
      end
    endcase
  end

  // framing control and output register
  always_comb begin
    receiving_d = receiving_q;
    wr_idx_d    = wr_idx_q;
    out_valid_d = out_valid_q && !out_ready_i;
    hit_d       = hit_q;
    if (accept) begin
      if (!receiving_q) begin
        if (rx_byte_i == START_MARK) begin
          receiving_d = 1'b1;
          wr_idx_d    = '0;
        end
      end else if (frame_end) begin
        receiving_d = 1'b0;
        out_valid_d = 1'b1;
        hit_d       = hit;
      end else begin
        wr_idx_d = wr_idx_q + CntW'(1);
        // drop the frame once the store is full
        if (wr_idx_d >= CntW'(FRAME_MAX)) begin
          receiving_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      receiving_q <= 1'b0;
      wr_idx_q    <= '0;
      out_valid_q <= 1'b0;
      hit_q       <= 1'b0;
      cmd_q       <= CMD_NONE;
      rate_q      <= RATE_RESET;
      text_q      <= RATE_TEXT_RESET;
      chan_q      <= CHAN_RESET;
      chch_q      <= CHAN_CHAR_RESET;
      for (int i = 0; i < FRAME_MAX; i++) begin
        frame_q[i] <= 8'h00;
      end
    end else begin
      receiving_q <= receiving_d;
      wr_idx_q    <= wr_idx_d;
      out_valid_q <= out_valid_d;
      hit_q       <= hit_d;
      if (accept && frame_end) begin
        cmd_q  <= cmd_d;
        rate_q <= rate_d;
        text_q <= text_d;
        chan_q <= chan_d;
        chch_q <= chch_d;
      end
      if (store_en) begin
        frame_q[wr_idx_q[IdxW-1:0]] <= rx_byte_i;
      end
    end
  end

  // command registers only change on an accepted closing '#', which needs the output slot free or being taken
  assign in_ready_o      = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign new_command_o   = hit_q;
  assign command_code_o  = cmd_q;
  assign rate_value_o    = rate_q;
  assign rate_text_o     = text_q;
  assign channel_value_o = chan_q;
  assign channel_char_o  = chch_q;

endmodule

`default_nettype wire

/* hdl/facd_checker.sv */
`default_nettype none

`include "framed_ascii_command_decoder_assert.svh"

module facd_sva (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic [7:0]  rx_byte_i,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic        new_command_o,
  input wire logic [2:0]  command_code_o,
  input wire logic [15:0] rate_value_o,
  input wire logic [31:0] rate_text_o,
  input wire logic [7:0]  channel_value_o,
  input wire logic [7:0]  channel_char_o
);

  import facd_pkg::*;

  // an empty output slot never stalls the input
  `FACD_ASSERT_IMP(a_ready_when_empty, !out_valid_o, in_ready_o, "input stalled with empty output")

  // a stalled result holds its payload
  `FACD_ASSERT_NEXT(a_result_holds, out_valid_o && !out_ready_i, out_valid_o && $stable(new_command_o) && $stable(command_code_o) && $stable(rate_value_o) && $stable(rate_text_o) && $stable(channel_value_o) && $stable(channel_char_o), "stalled result changed")

  // a fresh result follows only an accepted end mark
  `FACD_ASSERT_IMP(a_result_source, $rose(out_valid_o), $past(in_valid_i && in_ready_o && (rx_byte_i == END_MARK)), "result without end mark")

  // channel value always tracks its character
  `FACD_ASSERT_IMP(a_channel_pair, out_valid_o, channel_value_o == 8'(channel_char_o - ASCII_ZERO), "channel value and character disagree")

endmodule

bind framed_ascii_command_decoder facd_sva u_facd_sva (.*);

`default_nettype wire

/* tb/facd_checker.sv */
`timescale 1ns / 1ps

module facd_checker
  import facd_pkg::*;
#(
  parameter int unsigned FRAME_MAX = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic        new_command_i,
  input  logic [2:0]  command_code_i,
  input  logic [15:0] rate_value_i,
  input  logic [31:0] rate_text_i,
  input  logic [7:0]  channel_value_i,
  input  logic [7:0]  channel_char_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          reports_o,
  output int          hits_o
);

  typedef struct packed {
    logic        hit;
    cmd_e        code;
    logic [15:0] rate;
    logic [31:0] text;
    logic [7:0]  chan;
    logic [7:0]  chan_char;
  } cmd_report_t;

  cmd_report_t expected_reports[$];

  logic        in_frame;
  logic [3:0]  fill_idx;
  logic [7:0]  frame_mem [FRAME_MAX];
  logic [15:0] rate_q;
  logic [31:0] rate_text_q;
  logic [7:0]  chan_q;
  logic [7:0]  chan_char_q;
  cmd_e        cmd_q;

  always @(posedge clk_i or negedge rst_ni) begin : predict_and_check
    cmd_report_t want;
    logic        hit;
    logic [7:0]  f0, f1, f2, f3, f4, f5;
    logic [15:0] d2, d3, d4, d5;
    if (!rst_ni) begin
      in_frame    = 1'b0;
      fill_idx    = '0;
      for (int k = 0; k < FRAME_MAX; k++) frame_mem[k] = '0;
      rate_q      = RATE_RESET;
      rate_text_q = RATE_TEXT_RESET;
      chan_q      = CHAN_RESET;
      chan_char_q = CHAN_CHAR_RESET;
      cmd_q       = CMD_NONE;
      expected_reports.delete();
    end else begin
      // Compare first: a report taken at this edge never belongs to a byte
      // taken at the same edge.
      if (out_valid_i && out_ready_i) begin
        if (expected_reports.size() == 0) begin
          $error("report with no expectation: command_code %0d", command_code_i);
          fail_count_o++;
        end else begin
          want = expected_reports.pop_front();
          reports_o++;
          if (new_command_i !== want.hit) begin
            $error("new_command: expected %0d, got %0d", want.hit, new_command_i);
            fail_count_o++;
          end
          if (command_code_i !== want.code) begin
            $error("command_code: expected %0d, got %0d", want.code, command_code_i);
            fail_count_o++;
          end
          if (rate_value_i !== want.rate) begin
            $error("rate_value: expected %0d, got %0d", want.rate, rate_value_i);
            fail_count_o++;
          end
          if (rate_text_i !== want.text) begin
            $error("rate_text: expected %h, got %h", want.text, rate_text_i);
            fail_count_o++;
          end
          if (channel_value_i !== want.chan) begin
            $error("channel_value: expected %0d, got %0d", want.chan, channel_value_i);
            fail_count_o++;
          end
          if (channel_char_i !== want.chan_char) begin
            $error("channel_char: expected %h, got %h", want.chan_char, channel_char_i);
            fail_count_o++;
          end
        end
      end

      if (in_valid_i && in_ready_i) begin
        if (!in_frame) begin
          if (rx_byte_i == START_MARK) begin
            fill_idx = '0;
            in_frame = 1'b1;
          end
        end else if (rx_byte_i != END_MARK) begin
          if (fill_idx < FRAME_MAX) frame_mem[fill_idx] = rx_byte_i;
          fill_idx = fill_idx + 4'd1;
          // drop the frame once the store is full
          if (fill_idx >= FRAME_MAX) in_frame = 1'b0;
        end else begin
          // decode from fixed positions, stale bytes included
          f0 = frame_mem[0];
          f1 = frame_mem[1];
          f2 = frame_mem[2];
          f3 = frame_mem[3];
          f4 = frame_mem[4];
          f5 = frame_mem[5];
          d2 = {8'h00, f2} - {8'h00, ASCII_ZERO};
          d3 = {8'h00, f3} - {8'h00, ASCII_ZERO};
          d4 = {8'h00, f4} - {8'h00, ASCII_ZERO};
          d5 = {8'h00, f5} - {8'h00, ASCII_ZERO};
          hit = 1'b0;
          case (f0)
            CHAR_M: begin
              if (f1 == CHAR_0) begin
                cmd_q = CMD_STOP;
                hit   = 1'b1;
              end else if (f1 == CHAR_1) begin
                cmd_q = CMD_START;
                hit   = 1'b1;
              end
            end
            CHAR_C: begin
              if (f1 == CHAR_COMMA) begin
                if (f4 == CHAR_DOT) begin
                  rate_q      = d2 * 16'd10 + d3;
                  rate_text_q = {SPACE_CHAR, SPACE_CHAR, f2, f3};
                end else if (f5 == CHAR_DOT) begin
                  rate_q      = d2 * 16'd100 + d3 * 16'd10 + d4;
                  rate_text_q = {SPACE_CHAR, f2, f3, f4};
                end else begin
                  rate_q      = d2 * 16'd1000 + d3 * 16'd100 + d4 * 16'd10 + d5;
                  rate_text_q = {f2, f3, f4, f5};
                end
                cmd_q = CMD_RATE;
                hit   = 1'b1;
              end
            end
            CHAR_I: begin
              if (f1 == CHAR_COMMA && f3 == CHAR_DOT) begin
                chan_q      = f2 - ASCII_ZERO;
                chan_char_q = f2;
                cmd_q       = CMD_CHAN;
                hit         = 1'b1;
              end
            end
            CHAR_T: begin
              case (f1)
                CHAR_1: begin
                  cmd_q = CMD_TEST1;
                  hit   = 1'b1;
                end
                CHAR_2: begin
                  cmd_q = CMD_TEST2;
                  hit   = 1'b1;
                end
                CHAR_3: begin
                  cmd_q = CMD_TEST3;
                  hit   = 1'b1;
                end
                default: ;
              endcase
            end
            default: ;
          endcase
          in_frame       = 1'b0;
          want.hit       = hit;
          want.code      = cmd_q;
          want.rate      = rate_q;
          want.text      = rate_text_q;
          want.chan      = chan_q;
          want.chan_char = chan_char_q;
          expected_reports.push_back(want);
          if (hit) hits_o++;
        end
      end
    end
    pending_o = expected_reports.size();
  end

endmodule

/* tb/tb_framed_ascii_command_decoder.sv */
`timescale 1ns / 1ps

module tb_framed_ascii_command_decoder;
  import facd_pkg::*;

  localparam int CYCLE_LIMIT    = 400000;
  localparam int PHASE_ITEMS    = 125;
  localparam int FRAME_OVERFLOW = 8;

  logic        clk_i;
  logic        rst_ni    = 1'b0;
  logic        in_valid  = 1'b0;
  logic [7:0]  rx_byte   = '0;
  logic        out_ready = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic        new_command;
  logic [2:0]  command_code;
  logic [15:0] rate_value;
  logic [31:0] rate_text;
  logic [7:0]  channel_value;
  logic [7:0]  channel_char;

  int fail_count;
  int pending;
  int reports_seen;
  int hits_seen;
  int cycle_count     = 0;
  int bytes_sent      = 0;
  int noise_sent      = 0;
  int sender_idle_pct = 0;
  int stall_pct       = 0;
  int idle_tab[4]     = '{0, 73, 0, 26};
  int stall_tab[4]    = '{0, 0, 73, 26};

  framed_ascii_command_decoder uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .rx_byte_i      (rx_byte),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .new_command_o  (new_command),
    .command_code_o (command_code),
    .rate_value_o   (rate_value),
    .rate_text_o    (rate_text),
    .channel_value_o(channel_value),
    .channel_char_o (channel_char)
  );

  facd_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .rx_byte_i      (rx_byte),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .new_command_i  (new_command),
    .command_code_i (command_code),
    .rate_value_i   (rate_value),
    .rate_text_i    (rate_text),
    .channel_value_i(channel_value),
    .channel_char_i (channel_char),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .reports_o      (reports_seen),
    .hits_o         (hits_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk_i); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic send_seq(input logic [7:0] seq[$]);
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  // Hold the sender until every pending report has been taken.
  task automatic drain_reports();
    in_valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  function automatic logic [7:0] body_byte();
    if ($urandom_range(7) == 0) return START_MARK;
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] digit_char();
    if ($urandom_range(9) == 0) return 8'($urandom_range(255));
    return CHAR_0 + 8'($urandom_range(9));
  endfunction

  task automatic send_random_frame();
    logic [7:0] q[$];
    logic [7:0] b;
    int         kind;
    int         n;
    kind = $urandom_range(99);
    q    = {START_MARK};
    if (kind < 12) begin
      q.push_back(CHAR_M);
      case ($urandom_range(2))
        0: q.push_back(CHAR_0);
        1: q.push_back(CHAR_1);
        default: q.push_back(8'($urandom_range(255)));
      endcase
      q.push_back(END_MARK);
    end else if (kind < 32) begin
      q.push_back(CHAR_C);
      q.push_back(($urandom_range(9) == 0) ? 8'($urandom_range(255)) : CHAR_COMMA);
      n = $urandom_range(2, 4);
      repeat (n) q.push_back(digit_char());
      if (n < 4 || $urandom_range(1) == 0) q.push_back(CHAR_DOT);
      q.push_back(END_MARK);
    end else if (kind < 47) begin
      q.push_back(CHAR_I);
      q.push_back(($urandom_range(9) == 0) ? 8'($urandom_range(255)) : CHAR_COMMA);
      q.push_back(($urandom_range(2) == 0) ? 8'($urandom_range(255)) : digit_char());
      if ($urandom_range(9) != 0) q.push_back(CHAR_DOT);
      q.push_back(END_MARK);
    end else if (kind < 59) begin
      q.push_back(CHAR_T);
      case ($urandom_range(3))
        0: q.push_back(CHAR_1);
        1: q.push_back(CHAR_2);
        2: q.push_back(CHAR_3);
        default: q.push_back(8'($urandom_range(255)));
      endcase
      q.push_back(END_MARK);
    end else if (kind < 69) begin
      // short frame: decodes whatever the store still holds
      repeat ($urandom_range(3)) q.push_back(body_byte());
      q.push_back(END_MARK);
    end else if (kind < 78) begin
      // overflow (unless a body byte is '#'), then up to two random bytes, idle unless '$'
      repeat (FRAME_OVERFLOW) q.push_back(body_byte());
      repeat ($urandom_range(2)) q.push_back(8'($urandom_range(255)));
    end else if (kind < 88) begin
      repeat ($urandom_range(1, 7)) q.push_back(body_byte());
      q.push_back(END_MARK);
    end else begin
      q.delete();
      repeat ($urandom_range(1, 3)) begin
        b = 8'($urandom_range(255));
        if (b == START_MARK) b = ~b;
        q.push_back(b);
      end
      noise_sent += q.size();
    end
    send_seq(q);
  endtask

  initial begin
    logic [7:0] seq[$];
    int         phase_start;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed frames, no idling
    seq = {START_MARK, CHAR_M, CHAR_0, END_MARK};
    send_seq(seq);
    seq = {START_MARK, CHAR_C, CHAR_COMMA, CHAR_1, CHAR_2, CHAR_DOT, END_MARK};
    send_seq(seq);
    seq = {START_MARK, CHAR_I, CHAR_COMMA, CHAR_3, CHAR_DOT, END_MARK};
    send_seq(seq);
    // empty frame reuses the stale store
    seq = {START_MARK, END_MARK};
    send_seq(seq);
    // fill the store with extremes and a nested start mark, then an idle end mark
    seq = {START_MARK, 8'h00, START_MARK, 8'hFF, CHAR_M, CHAR_0, CHAR_1, CHAR_2, CHAR_3,
           END_MARK};
    send_seq(seq);
    drain_reports();

    for (int p = 0; p < 4; p++) begin
      sender_idle_pct <= idle_tab[p];
      stall_pct       <= stall_tab[p];
      phase_start = bytes_sent - noise_sent;
      while ((bytes_sent - noise_sent) - phase_start < PHASE_ITEMS) send_random_frame();
      drain_reports();
    end

    repeat (16) @(posedge clk_i);
    $display("Sent %0d frame bytes and %0d idle noise bytes over four pacing phases.",
             bytes_sent - noise_sent, noise_sent);
    $display("Checked %0d reports, %0d of them decoded a command.", reports_seen, hits_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hdl
hdl/facd_pkg.sv
hdl/framed_ascii_command_decoder.sv
hdl/facd_checker.sv
tb/facd_checker.sv
tb/tb_framed_ascii_command_decoder.sv
